### hw/rtl/rotation_matrix_to_quaternion_defines.svh
// Assertion macros for the matrix to quaternion block
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define RMQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RMQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/rmq_pkg.sv
// Shared types, widths and helpers of the matrix to quaternion block
`default_nettype none
package rmq_pkg;

  localparam int W          = 16;
  localparam int D_W        = 17;  // pair sum or difference, and its magnitude
  localparam int F_W        = 18;  // f + 1 in Q.14, padded to even width
  localparam int ROOT_W     = 24;
  localparam int REM_W      = 27;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int NUM_W      = 39;
  localparam int Q_W        = 18;
  localparam int DIV_STEPS  = Q_W;
  localparam int DSH_W      = ROOT_W + Q_W - 1;
  localparam int LANES      = 3;
  localparam int NUM_SHIFT  = 21;

  typedef enum logic [1:0] {
    PIV_W = 2'd0,
    PIV_X = 2'd1,
    PIV_Y = 2'd2,
    PIV_Z = 2'd3
  } piv_e;

  typedef struct packed {
    piv_e                        piv;
    logic [LANES-1:0]            neg;
    logic [LANES-1:0][D_W-1:0]   mag;
  } side_t;

  typedef struct packed {
    logic              valid;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [F_W-1:0]    fsh;
    side_t             side;
  } sq_t;

  typedef struct packed {
    logic                        valid;
    piv_e                        piv;
    logic [LANES-1:0]            neg;
    logic [LANES-1:0][NUM_W-1:0] rem;
    logic [LANES-1:0][Q_W-1:0]   quo;
    logic [DSH_W-1:0]            dsh;
    logic [ROOT_W-1:0]           root;
  } dv_t;

  // s/2 in Q2.14, rounded half up, saturated
  function automatic logic [W-1:0] sat_piv(input logic [ROOT_W-1:0] t);
    logic [ROOT_W:0] sum;
    logic [W-1:0]    p;
    sum = {1'b0, t} + (ROOT_W+1)'(256);
    p   = sum[ROOT_W:9];
    if (p[W-1]) return 16'h7FFF;
    return p;
  endfunction

  function automatic logic [W-1:0] sat_off(input logic neg, input logic [Q_W-1:0] q);
    logic [Q_W-1:0] nq;
    nq = -q;
    if (neg) begin
      if (q >= Q_W'(32768)) return 16'h8000;
      return nq[W-1:0];
    end
    if (q > Q_W'(32767)) return 16'h7FFF;
    return q[W-1:0];
  endfunction

endpackage
`default_nettype wire

### hw/rtl/rmq_if.sv
// Valid/ready channels carrying matrix beats in and quaternion beats out
`default_nettype none
interface rmq_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] right_x, right_y, right_z;
  logic signed [15:0] up_x, up_y, up_z;
  logic signed [15:0] at_x, at_y, at_z;
  modport source (output valid, right_x, right_y, right_z, up_x, up_y, up_z,
                  at_x, at_y, at_z, input ready);
  modport sink   (input valid, right_x, right_y, right_z, up_x, up_y, up_z,
                  at_x, at_y, at_z, output ready);
endinterface

interface rmq_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] quat_x, quat_y, quat_z, quat_w;
  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface
`default_nettype wire

### hw/rtl/rmq_sqrt_cell.sv
// One digit of the pipelined integer square root
`default_nettype none
module rmq_sqrt_cell
  import rmq_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  en_i,
  input  sq_t  cell_i,
  output sq_t  cell_o
);
  sq_t              pay_d, pay_q;
  logic             vld_q;
  logic [REM_W-1:0] rem_sh, trial;
  logic             ge;

  always_comb begin
    rem_sh = {cell_i.rem[REM_W-3:0], cell_i.fsh[F_W-1 -: 2]};
    trial  = {1'b0, cell_i.root, 2'b01};
    ge     = rem_sh >= trial;
    pay_d       = cell_i;
    pay_d.rem   = ge ? rem_sh - trial : rem_sh;
    pay_d.root  = {cell_i.root[ROOT_W-2:0], ge};
    pay_d.fsh   = {cell_i.fsh[F_W-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pay_q <= pay_d;
    end
  end

  always_comb begin
    cell_o       = pay_q;
    cell_o.valid = vld_q;
  end
endmodule
`default_nettype wire

### hw/rtl/rmq_div_cell.sv
// One quotient bit of the three restoring dividers that share the root
`default_nettype none
module rmq_div_cell
  import rmq_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  en_i,
  input  dv_t  cell_i,
  output dv_t  cell_o
);
  dv_t  pay_d, pay_q;
  logic vld_q;
  logic [LANES-1:0] ge;

  always_comb begin
    pay_d = cell_i;
    for (int l = 0; l < LANES; l++) begin
      ge[l] = {2'b00, cell_i.rem[l]} >= cell_i.dsh;
      pay_d.rem[l] = ge[l] ? cell_i.rem[l] - cell_i.dsh[NUM_W-1:0] : cell_i.rem[l];
      pay_d.quo[l] = {cell_i.quo[l][Q_W-2:0], ge[l]};
    end
    pay_d.dsh = cell_i.dsh >> 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pay_q <= pay_d;
    end
  end

  always_comb begin
    cell_o       = pay_q;
    cell_o.valid = vld_q;
  end
endmodule
`default_nettype wire

### hw/rtl/rotation_matrix_to_quaternion.sv
// Throughput: one beat per cycle while the output beat is not held; the entry stage,
// 24 square-root cells, a numerator stage, 18 divider cells and the output
// register all step together.
// A held output beat stalls the whole chain, so input ready follows output space.
// Reset clears only the valid bits of the chain; data registers are not reset.
`default_nettype none
`include "rotation_matrix_to_quaternion_defines.svh"
module rotation_matrix_to_quaternion
  import rmq_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  rmq_in_if.sink     in_i,
  rmq_out_if.source  out_o
);
  logic en;
  logic out_vld_q;
  logic [W-1:0] qx_q, qy_q, qz_q, qw_q;

  assign en         = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  // ---- entry: branch select, f + 1, off-diagonal pairs
  logic signed [F_W-1:0] rx, uy, az, tr, rd, ud, zd, f_sel;
  logic signed [D_W-1:0] d_uz_ay, d_ax_rz, d_ry_ux, s_ux_ry, s_ax_rz, s_ay_uz;
  logic signed [D_W-1:0] dl [LANES];
  sq_t  ent_d;

  always_comb begin
    rx = F_W'(in_i.right_x);
    uy = F_W'(in_i.up_y);
    az = F_W'(in_i.at_z);
    tr = rx + uy + az;
    rd = rx - uy - az;
    ud = uy - rx - az;
    zd = az - uy - rx;
    d_uz_ay = D_W'(in_i.up_z) - D_W'(in_i.at_y);
    d_ax_rz = D_W'(in_i.at_x) - D_W'(in_i.right_z);
    d_ry_ux = D_W'(in_i.right_y) - D_W'(in_i.up_x);
    s_ux_ry = D_W'(in_i.up_x) + D_W'(in_i.right_y);
    s_ax_rz = D_W'(in_i.at_x) + D_W'(in_i.right_z);
    s_ay_uz = D_W'(in_i.at_y) + D_W'(in_i.up_z);
    ent_d = '0;
    if (!tr[F_W-1]) begin
      ent_d.side.piv = PIV_W; f_sel = tr;
      dl[0] = d_uz_ay; dl[1] = d_ax_rz; dl[2] = d_ry_ux;
    end else if (!rd[F_W-1]) begin
      ent_d.side.piv = PIV_X; f_sel = rd;
      dl[0] = s_ux_ry; dl[1] = s_ax_rz; dl[2] = d_uz_ay;
    end else if (!ud[F_W-1]) begin
      ent_d.side.piv = PIV_Y; f_sel = ud;
      dl[0] = s_ux_ry; dl[1] = s_ay_uz; dl[2] = d_ax_rz;
    end else begin
      ent_d.side.piv = PIV_Z; f_sel = zd;
      dl[0] = s_ax_rz; dl[1] = s_ay_uz; dl[2] = d_ry_ux;
    end
    for (int l = 0; l < LANES; l++) begin
      ent_d.side.neg[l] = dl[l][D_W-1];
      ent_d.side.mag[l] = dl[l][D_W-1] ? D_W'(-dl[l]) : D_W'(dl[l]);
    end
    ent_d.fsh   = f_sel + F_W'(16384);
    ent_d.valid = in_i.valid;
  end

  sq_t ent_q;
  logic ent_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= 1'b0;
    end else if (en) begin
      ent_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ent_q <= ent_d;
    end
  end

  // ---- square-root chain: T = floor(sqrt((f + 1) << 30))
  sq_t sq [SQRT_STEPS+1];

  always_comb begin
    sq[0]       = ent_q;
    sq[0].valid = ent_vld_q;
  end

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    rmq_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cell_i (sq[i]),
      .cell_o (sq[i+1])
    );
  end

  // ---- numerators |d| << 21 + T/2, divisor T aligned to the top quotient bit
  dv_t num_d, num_q;
  logic num_vld_q;

  always_comb begin
    num_d       = '0;
    num_d.valid = sq[SQRT_STEPS].valid;
    num_d.piv   = sq[SQRT_STEPS].side.piv;
    num_d.neg   = sq[SQRT_STEPS].side.neg;
    num_d.root  = sq[SQRT_STEPS].root;
    num_d.dsh   = {sq[SQRT_STEPS].root, (Q_W-1)'(0)};
    for (int l = 0; l < LANES; l++) begin
      num_d.rem[l] = NUM_W'({sq[SQRT_STEPS].side.mag[l], NUM_SHIFT'(0)})
                   + NUM_W'(sq[SQRT_STEPS].root >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_vld_q <= 1'b0;
    end else if (en) begin
      num_vld_q <= sq[SQRT_STEPS].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q <= num_d;
    end
  end

  // ---- divider chain
  dv_t dv [DIV_STEPS+1];

  always_comb begin
    dv[0]       = num_q;
    dv[0].valid = num_vld_q;
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    rmq_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cell_i (dv[i]),
      .cell_o (dv[i+1])
    );
  end

  // ---- output: saturate and place the pivot
  logic [W-1:0] piv, l0, l1, l2;
  logic [W-1:0] qx_d, qy_d, qz_d, qw_d;

  always_comb begin
    piv = sat_piv(dv[DIV_STEPS].root);
    l0  = sat_off(dv[DIV_STEPS].neg[0], dv[DIV_STEPS].quo[0]);
    l1  = sat_off(dv[DIV_STEPS].neg[1], dv[DIV_STEPS].quo[1]);
    l2  = sat_off(dv[DIV_STEPS].neg[2], dv[DIV_STEPS].quo[2]);
    case (dv[DIV_STEPS].piv)
      PIV_W: begin qx_d = l0;  qy_d = l1;  qz_d = l2;  qw_d = piv; end
      PIV_X: begin qx_d = piv; qy_d = l0;  qz_d = l1;  qw_d = l2;  end
      PIV_Y: begin qx_d = l0;  qy_d = piv; qz_d = l1;  qw_d = l2;  end
      PIV_Z: begin qx_d = l0;  qy_d = l1;  qz_d = piv; qw_d = l2;  end
      default: begin qx_d = l0; qy_d = l1; qz_d = l2; qw_d = piv; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv[DIV_STEPS].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      qx_q <= qx_d;
      qy_q <= qy_d;
      qz_q <= qz_d;
      qw_q <= qw_d;
    end
  end

  assign out_o.valid  = out_vld_q;
  assign out_o.quat_x = qx_q;
  assign out_o.quat_y = qy_q;
  assign out_o.quat_z = qz_q;
  assign out_o.quat_w = qw_q;

  `RMQ_ASSERT_IMP(a_held_beat_stalls_input, out_vld_q && !out_o.ready, !in_i.ready, "input taken while output beat held")
  `RMQ_ASSERT_NEXT(a_accept_enters_chain, in_i.valid && in_i.ready, ent_vld_q, "accepted beat lost at entry")
  `RMQ_ASSERT_NEXT(a_chain_end_reaches_out, en && dv[DIV_STEPS].valid, out_vld_q, "beat lost at output register")
  `RMQ_ASSERT_NEXT(a_stall_freezes_root, !en && sq[SQRT_STEPS].valid, $stable(sq[SQRT_STEPS].root), "root moved during stall")

endmodule
`default_nettype wire
